// ===== rtl/sgemm_pkg.sv =====
// Package for the small GEMM block: action codes, config indices, sequencer states,
// unit op codes and fp32/fp16 quiet NaN constants. No dependencies.
package sgemm_pkg;

    typedef enum logic [1:0] {
        ACT_LOAD_A = 2'd0,
        ACT_LOAD_B = 2'd1,
        ACT_LOAD_C = 2'd2,
        ACT_START  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        CFG_TRANS_A = 3'd0,
        CFG_TRANS_B = 3'd1,
        CFG_ROWS_M  = 3'd2,
        CFG_COLS_N  = 3'd3,
        CFG_DEPTH_K = 3'd4,
        CFG_ALPHA   = 3'd5,
        CFG_BETA    = 3'd6,
        CFG_HALF    = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDK,     // issue A/B reads for step k
        ST_WAITK,   // read data lands
        ST_MUL,     // prod = a*b
        ST_ADD,     // sum = sum + prod
        ST_ALPHA,   // res = alpha*sum, issue C read
        ST_BMUL,    // t = beta*c
        ST_BADD,    // res = res + t
        ST_FIN,     // nan canon, fp16, write back
        ST_OUT      // hold result until taken
    } t_state;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_ADD = 1'b1
    } t_fop;

    localparam logic [31:0] QNAN32 = 32'h7FC0_0000;
    localparam logic [15:0] QNAN16 = 16'h7E00;

endpackage

// ===== rtl/sgemm_fpu.sv =====
// Shared fp32 multiply/add unit, round to nearest even; operand decode and
// multiply/align are registered, then normalize/round is registered.
// Depends on sgemm_pkg.
module sgemm_fpu (
    input  logic             i_clk,
    input  logic             i_go,
    input  sgemm_pkg::t_fop  i_op,
    input  logic [31:0]      i_a,
    input  logic [31:0]      i_b,
    output logic [31:0]      o_res
);
    import sgemm_pkg::*;

    // stage 1 results: sign, exponent (biased, signed wide), magnitude 50 bits
    // with value = mag * 2^(exp - 127 - 46) ; special flags
    logic               r_sign, r_nan, r_inf, r_zero;
    logic signed [10:0] r_exp;
    logic [49:0]        r_mag;
    logic               r_zsign;
    logic [31:0]        r_res;

    logic        sa, sb;
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;
    logic        na, nb, ia, ib, za, zb;
    logic        n_sign, n_nan, n_inf, n_zero, n_zsign;
    logic signed [10:0] n_exp;
    logic [49:0] n_mag;
    logic [47:0] prod;
    logic [8:0]  ead, ebd;
    logic [49:0] big, sml, sh;
    logic [8:0]  diff;
    logic        sbig, ssml, sticky;

    always_comb begin
        sa = i_a[31]; sb = i_b[31];
        ea = i_a[30:23]; eb = i_b[30:23];
        ma = {(ea != 8'd0), i_a[22:0]};
        mb = {(eb != 8'd0), i_b[22:0]};
        na = (ea == 8'hFF) && (i_a[22:0] != 23'd0);
        nb = (eb == 8'hFF) && (i_b[22:0] != 23'd0);
        ia = (ea == 8'hFF) && (i_a[22:0] == 23'd0);
        ib = (eb == 8'hFF) && (i_b[22:0] == 23'd0);
        za = (i_a[30:0] == 31'd0);
        zb = (i_b[30:0] == 31'd0);
        ead = (ea == 8'd0) ? 9'd1 : {1'b0, ea};
        ebd = (eb == 8'd0) ? 9'd1 : {1'b0, eb};
        prod = ma * mb;
        n_sign = 1'b0; n_nan = 1'b0; n_inf = 1'b0; n_zero = 1'b0;
        n_zsign = 1'b0; n_exp = '0; n_mag = '0;
        big = '0; sml = '0; sh = '0; diff = '0; sbig = 1'b0; ssml = 1'b0;
        sticky = 1'b0;
        if (i_op == OP_MUL) begin
            n_sign = sa ^ sb;
            n_nan  = na || nb || (ia && zb) || (ib && za);
            n_inf  = ia || ib;
            n_zero = za || zb;
            n_zsign = sa ^ sb;
            // prod has 46 fraction bits; value = prod*2^(ead+ebd-254-46)
            n_exp = 11'(signed'({2'b0, ead})) + 11'(signed'({2'b0, ebd})) - 11'sd127;
            n_mag = {2'b0, prod};
        end else begin
            n_nan = na || nb || (ia && ib && (sa != sb));
            n_inf = ia || ib;
            n_sign = ia ? sa : sb;
            n_zero = 1'b0;
            n_zsign = sa & sb;
            // mags with 23 fraction bits placed at bit 46 (shift 23, 3 headroom bits on top)
            if ({ead, ma} >= {ebd, mb}) begin
                big = {3'b0, ma, 23'd0}; sml = {3'b0, mb, 23'd0};
                diff = ead - ebd; sbig = sa; ssml = sb;
                n_exp = 11'(signed'({2'b0, ead}));
            end else begin
                big = {3'b0, mb, 23'd0}; sml = {3'b0, ma, 23'd0};
                diff = ebd - ead; sbig = sb; ssml = sa;
                n_exp = 11'(signed'({2'b0, ebd}));
            end
            if (diff > 9'd49) begin
                sh = '0; sticky = (sml != '0);
            end else begin
                sh = sml >> diff;
                sticky = ((sh << diff) != sml);
            end
            sh = sh | {49'd0, sticky};
            if (!n_inf) n_sign = sbig;
            n_mag = (sbig == ssml) ? (big + sh) : (big - sh);
            if (n_mag == '0 && !n_inf) n_zero = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_sign <= n_sign; r_nan <= n_nan; r_inf <= n_inf; r_zero <= n_zero;
            r_zsign <= n_zsign; r_exp <= n_exp; r_mag <= n_mag;
        end
    end

    // stage 2: normalize so leading one at bit 49, value = 1.x * 2^(exp-127)
    logic [5:0]  lz;
    logic [49:0] nm;
    logic signed [11:0] e2;
    logic [49:0] dm;
    logic [11:0] rsh;
    logic [23:0] keep;
    logic        g, st, inc;
    logic [24:0] rnd;
    logic signed [11:0] ef;
    logic [31:0] n_res;

    always_comb begin
        lz = '0;
        for (int i = 0; i < 50; i++) begin
            if (r_mag[i]) lz = 6'(49 - i);
        end
        nm = r_mag << lz;               // leading one at bit 49
        e2 = 12'(r_exp) + 12'sd3 - 12'(signed'({6'd0, lz}));
        // mantissa = nm[49:26], remainder nm[25:0]
        dm = nm; rsh = '0;
        if (e2 < 12'sd1) begin
            rsh = 12'(12'sd1 - e2);
            if (rsh > 12'd49) dm = {49'd0, (nm != '0)};
            else dm = (nm >> rsh[5:0]) | {49'd0, ((nm << (6'd50 - rsh[5:0])) != '0)};
            e2 = 12'sd1;
        end
        keep = dm[49:26];
        g = dm[25];
        st = (dm[24:0] != '0);
        inc = g && (st || keep[0]);
        rnd = {1'b0, keep} + {24'd0, inc};
        ef = e2;
        if (rnd[24]) begin
            rnd = rnd >> 1; ef = e2 + 12'sd1;
        end
        if (r_nan) n_res = QNAN32;
        else if (r_inf) n_res = {r_sign, 8'hFF, 23'd0};
        else if (r_zero) n_res = {r_zsign, 31'd0};
        else if (ef >= 12'sd255) n_res = {r_sign, 8'hFF, 23'd0};
        else if (!rnd[23]) n_res = {r_sign, 8'd0, rnd[22:0]};
        else n_res = {r_sign, ef[7:0], rnd[22:0]};
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;
endmodule

// ===== rtl/small_gemm_alpha_beta.sv =====
// Small GEMM top level: A/B/C stores, sequencer, shared fp32 unit.
// Depends on sgemm_pkg and sgemm_fpu.
//
//  channel  dir  fields (low bit up)
//  s_axis   in   tdata: action[1:0] slot[7:2] element_bits[39:8]
//  m_axis   out  tdata: out_row[2:0] out_col[5:3] out_bits[37:6]; tlast: last
//  cfg      in   i_cfg_we, i_cfg_idx, i_cfg_data
//
// Loads are accepted back to back while idle. Start runs per element: each k step
// is a read, a read wait, and a multiply and an add through the single shared
// unit; then alpha scales the sum and, unless beta is zero, beta*C is added.
// Output waits in a register while m_axis stalls.
// Reset clears control and config; stores are undefined until loaded.
module small_gemm_alpha_beta #(
    parameter int MAX_DIM = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // action, slot, element_bits
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // out_row, out_col, out_bits, pad
    output logic        m_axis_tlast    // last
);
    import sgemm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW = $clog2(DEPTH);
    localparam int DW = $clog2(MAX_DIM + 1);

    logic        r_ta, r_tb, r_half;
    logic [3:0]  r_m, r_n, r_k;
    logic [31:0] r_alpha, r_beta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ta <= 1'b0; r_tb <= 1'b0; r_half <= 1'b0;
            r_m <= 4'd1; r_n <= 4'd1; r_k <= 4'd1;
            r_alpha <= 32'h3F80_0000; r_beta <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TRANS_A: r_ta <= i_cfg_data[0];
                CFG_TRANS_B: r_tb <= i_cfg_data[0];
                CFG_ROWS_M:  r_m <= i_cfg_data[3:0];
                CFG_COLS_N:  r_n <= i_cfg_data[3:0];
                CFG_DEPTH_K: r_k <= i_cfg_data[3:0];
                CFG_ALPHA:   r_alpha <= i_cfg_data;
                CFG_BETA:    r_beta <= i_cfg_data;
                CFG_HALF:    r_half <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    function automatic logic [DW-1:0] clampd(input logic [3:0] d);
        if (d == 4'd0) return DW'(1);
        if (32'(d) > MAX_DIM) return DW'(MAX_DIM);
        return DW'(d);
    endfunction

    logic [DW-1:0] dm, dn, dk;
    assign dm = clampd(r_m);
    assign dn = clampd(r_n);
    assign dk = clampd(r_k);

    t_action     in_act;
    logic [5:0]  in_slot;
    logic [31:0] in_elem;
    assign in_act  = t_action'(s_axis_tdata[1:0]);
    assign in_slot = s_axis_tdata[7:2];
    assign in_elem = s_axis_tdata[39:8];

    t_state r_st, n_st;
    logic [DW-1:0] r_i, r_j, r_kk;
    logic [31:0]   r_sum, r_tmp, r_out;
    logic [31:0]   r_ad, r_bd, r_cd;
    logic [31:0] a_mem [DEPTH];
    logic [31:0] b_mem [DEPTH];
    logic [31:0] c_mem [DEPTH];
    logic [AW-1:0] a_addr, b_addr, c_addr;
    logic [1:0]  r_wt;
    logic        acc, in_range, skip_c, last_el;

    assign acc = s_axis_tvalid && s_axis_tready;
    assign in_range = (32'(in_slot) < DEPTH);
    assign skip_c = (r_beta[30:0] == 31'd0);
    assign last_el = (r_i == dm - DW'(1)) && (r_j == dn - DW'(1));

    always_comb begin
        a_addr = r_ta ? (AW'(r_kk) * AW'(dm) + AW'(r_i))
                      : (AW'(r_i) * AW'(dk) + AW'(r_kk));
        b_addr = r_tb ? (AW'(r_j) * AW'(dk) + AW'(r_kk))
                      : (AW'(r_kk) * AW'(dn) + AW'(r_j));
        c_addr = AW'(r_i) * AW'(dn) + AW'(r_j);
    end

    // fp16 conversion and widening of the finished value
    logic [31:0] res_c, h16, w32;
    always_comb begin
        logic [7:0]  e;
        logic [22:0] mm;
        logic [15:0] h;
        logic [12:0] rem;
        logic [23:0] fm, q, rm, hf;
        logic [4:0]  s;
        logic [4:0]  he;
        logic [9:0]  hm;
        logic [3:0]  lz;
        res_c = ((r_tmp[30:23] == 8'hFF) && (r_tmp[22:0] != 0)) ? QNAN32 : r_tmp;
        e = res_c[30:23]; mm = res_c[22:0];
        h = {res_c[31], 15'd0}; fm = '0; q = '0; rm = '0; hf = '0; s = '0; rem = '0;
        if (e == 8'hFF) h = (mm != 0) ? QNAN16 : {res_c[31], 15'h7C00};
        else if (e >= 8'd143) h = {res_c[31], 15'h7C00};
        else if (e >= 8'd113) begin
            h = {res_c[31], 5'(e - 8'd112), mm[22:13]};
            rem = mm[12:0];
            if (rem > 13'h1000 || (rem == 13'h1000 && h[0])) h = h + 16'd1;
        end else if (e >= 8'd102) begin
            fm = {1'b1, mm};
            s = 5'(8'd126 - e);
            q = fm >> s;
            rm = fm & ((24'd1 << s) - 24'd1);
            hf = 24'd1 << (s - 5'd1);
            if (rm > hf || (rm == hf && q[0])) q = q + 24'd1;
            h = {res_c[31], 15'(q)};
        end
        h16 = {16'd0, h};
        he = h[14:10]; hm = h[9:0]; lz = '0;
        if (he == 5'd31) w32 = {h[15], 8'hFF, hm, 13'd0};
        else if (he != 5'd0) w32 = {h[15], 8'(he) + 8'd112, hm, 13'd0};
        else if (hm == 10'd0) w32 = {h[15], 31'd0};
        else begin
            for (int i = 0; i < 10; i++) if (hm[i]) lz = 4'(9 - i);
            w32 = {h[15], 8'd113 - 8'(lz) - 8'd1,
                   (hm << (lz + 4'd1)), 13'd0};
        end
    end

    // shared fp unit
    logic        fgo;
    t_fop        fop;
    logic [31:0] fa, fb, fr;
    sgemm_fpu u_fpu (
        .i_clk(i_clk), .i_go(fgo), .i_op(fop), .i_a(fa), .i_b(fb), .o_res(fr)
    );

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE:  if (acc && in_act == ACT_START) n_st = ST_RDK;
            ST_RDK:   n_st = ST_WAITK;
            ST_WAITK: n_st = ST_MUL;
            ST_MUL:   if (r_wt == 2'd2) n_st = ST_ADD;
            ST_ADD:   if (r_wt == 2'd2) n_st = (r_kk == dk - DW'(1)) ? ST_ALPHA : ST_RDK;
            ST_ALPHA: if (r_wt == 2'd2) n_st = skip_c ? ST_FIN : ST_BMUL;
            ST_BMUL:  if (r_wt == 2'd2) n_st = ST_BADD;
            ST_BADD:  if (r_wt == 2'd2) n_st = ST_FIN;
            ST_FIN:   n_st = ST_OUT;
            ST_OUT:   if (m_axis_tready) n_st = last_el ? ST_IDLE : ST_RDK;
            default:  n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        fgo = 1'b0; fop = OP_MUL; fa = r_ad; fb = r_bd;
        case (r_st)
            ST_MUL:   fgo = (r_wt == 2'd0);
            ST_ADD:   begin fgo = (r_wt == 2'd0); fop = OP_ADD; fa = r_sum; fb = r_tmp; end
            ST_ALPHA: begin fgo = (r_wt == 2'd0); fa = r_alpha; fb = r_sum; end
            ST_BMUL:  begin fgo = (r_wt == 2'd0); fa = r_beta; fb = r_cd; end
            ST_BADD:  begin fgo = (r_wt == 2'd0); fop = OP_ADD; fa = r_sum; fb = r_tmp; end
            default: ;
        endcase
    end

    assign s_axis_tready = (r_st == ST_IDLE);
    assign m_axis_tvalid = (r_st == ST_OUT);
    assign m_axis_tdata  = {2'b0, r_out, 3'(r_j), 3'(r_i)};
    assign m_axis_tlast  = last_el;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_i <= '0; r_j <= '0; r_kk <= '0; r_wt <= '0;
        end else begin
            r_st <= n_st;
            if (r_st != n_st) r_wt <= '0;
            else if (r_wt != 2'd2) r_wt <= r_wt + 2'd1;
            case (r_st)
                ST_IDLE: begin r_i <= '0; r_j <= '0; r_kk <= '0; end
                ST_ADD: begin
                    if (r_wt == 2'd2 && r_kk != dk - DW'(1)) r_kk <= r_kk + DW'(1);
                end
                ST_OUT: if (m_axis_tready) begin
                    r_kk <= '0;
                    if (r_j == dn - DW'(1)) begin
                        r_j <= '0; r_i <= r_i + DW'(1);
                    end else r_j <= r_j + DW'(1);
                end
                default: ;
            endcase
        end
    end

    // r_tmp takes unit results; r_sum accumulates
    always_ff @(posedge i_clk) begin
        if (r_st == ST_IDLE) r_sum <= '0;
        if (r_wt == 2'd2) begin
            case (r_st)
                ST_MUL:   r_tmp <= fr;
                ST_ADD:   r_sum <= fr;
                ST_ALPHA: begin r_sum <= fr; r_tmp <= fr; end
                ST_BMUL:  r_tmp <= fr;
                ST_BADD:  r_tmp <= fr;
                default: ;
            endcase
        end
        if (r_st == ST_FIN) r_out <= r_half ? h16 : res_c;
        if (r_st == ST_OUT && m_axis_tready) r_sum <= '0;
    end

    // stores
    always_ff @(posedge i_clk) begin
        if (acc && in_range && in_act == ACT_LOAD_A) a_mem[in_slot[AW-1:0]] <= in_elem;
        if (acc && in_range && in_act == ACT_LOAD_B) b_mem[in_slot[AW-1:0]] <= in_elem;
        if (acc && in_range && in_act == ACT_LOAD_C) c_mem[in_slot[AW-1:0]] <= in_elem;
        else if (r_st == ST_FIN) c_mem[c_addr] <= r_half ? w32 : res_c;
        r_ad <= a_mem[a_addr];
        r_bd <= b_mem[b_addr];
        r_cd <= c_mem[c_addr];
    end

    ap_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != ST_IDLE) |-> !s_axis_tready) else $error("accept while busy");
    ap_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output changed while stalled");
    ap_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != ST_IDLE) |-> (r_i < dm && r_j < dn && r_kk < dk))
        else $error("index out of range");
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for small_gemm_alpha_beta: a bit-exact fp32 GEMM predictor
// checks every streamed C element against the block. Depends on sgemm_pkg and the RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sgemm_pkg::*;

    typedef struct {
        t_action     act;
        logic [5:0]  slot;
        logic [31:0] elem;
    } t_req;

    typedef struct {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] bits;
        logic        last;
    } t_elem;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = 3'd0;
    logic [31:0] i_cfg_data = 32'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = 40'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    t_req        req_q[$];
    t_req        cur_req;
    t_elem       c_expect_q[$];
    int          n_errors = 0;
    int          n_sent = 0;
    int          n_acc = 0;
    bit          idle_en = 1'b1;
    int          src_gap = 0;
    int          snk_stall = 0;

    // predictor copy of the registers and stores
    bit          p_trans_a, p_trans_b, p_half;
    logic [3:0]  p_m, p_n, p_k;
    logic [31:0] p_alpha, p_beta;
    logic [31:0] mat_a[64], mat_b[64], mat_c[64];
    bit          seen_a[64], seen_b[64], seen_c[64];

    small_gemm_alpha_beta i_dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic bit is_nan32(logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] != 0;
    endfunction

    function automatic bit is_inf32(logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] == 0;
    endfunction

    // value = sig * 2^e
    function automatic void split32(input logic [31:0] x, output logic [63:0] sig,
                                    output int e);
        if (x[30:23] == 0) begin
            sig = {41'd0, x[22:0]};
            e = -149;
        end else begin
            sig = {40'd0, 1'b1, x[22:0]};
            e = int'(x[30:23]) - 150;
        end
    endfunction

    // round sig * 2^e to fp32, nearest even; sticky already folded into low bits
    function automatic logic [31:0] round32(bit s, int e, logic [63:0] sig);
        int p, sh, be;
        logic [63:0] q, rem, half;
        if (sig == 0) return {s, 31'd0};
        p = 63;
        while (!sig[p]) p--;
        sh = p - 23;
        if (-149 - e > sh) sh = -149 - e;
        if (sh >= 64) begin
            q = 0;
        end else if (sh > 0) begin
            q = sig >> sh;
            rem = sig & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && q[0])) q++;
        end else begin
            q = sig << (-sh);
        end
        if (q[24]) begin
            q = q >> 1;
            sh++;
        end
        if (!q[23]) return {s, 8'd0, q[22:0]};
        be = e + sh + 150;
        if (be >= 255) return {s, 8'hFF, 23'd0};
        return {s, be[7:0], q[22:0]};
    endfunction

    function automatic logic [31:0] fmul32(logic [31:0] a, logic [31:0] b);
        bit s;
        int ea, eb;
        logic [63:0] sa, sb;
        s = a[31] ^ b[31];
        if (is_nan32(a) || is_nan32(b)) return QNAN32;
        if (is_inf32(a) || is_inf32(b)) begin
            if (a[30:0] == 0 || b[30:0] == 0) return QNAN32;
            return {s, 8'hFF, 23'd0};
        end
        if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'd0};
        split32(a, sa, ea);
        split32(b, sb, eb);
        return round32(s, ea + eb, sa * sb);
    endfunction

    function automatic logic [31:0] fadd32(logic [31:0] a, logic [31:0] b);
        int ea, eb, d;
        logic [63:0] sa, sb, big, sml, al, res;
        logic [31:0] x, y;
        bit sx;
        if (is_nan32(a) || is_nan32(b)) return QNAN32;
        if (is_inf32(a) && is_inf32(b) && a[31] != b[31]) return QNAN32;
        if (is_inf32(a)) return a;
        if (is_inf32(b)) return b;
        if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
        if (a[30:0] == 0) return b;
        if (b[30:0] == 0) return a;
        if (a[30:0] >= b[30:0]) begin
            x = a;
            y = b;
        end else begin
            x = b;
            y = a;
        end
        split32(x, sa, ea);
        split32(y, sb, eb);
        sx = x[31];
        d = ea - eb;
        big = sa << 38;
        sml = sb << 38;
        if (d >= 63) al = 64'd1;
        else al = (sml >> d) | ((sml & ((64'd1 << d) - 1)) != 0);
        if (x[31] == y[31]) res = big + al;
        else res = big - al;
        if (res == 0) return 32'd0;
        return round32(sx, ea - 38, res);
    endfunction

    function automatic logic [15:0] narrow16(logic [31:0] x);
        logic [15:0] sg, h;
        int ex, sh;
        logic [31:0] mant, q, rem, half;
        sg = {x[31], 15'd0};
        ex = int'(x[30:23]);
        mant = {9'd0, x[22:0]};
        if (ex == 255) return (mant != 0) ? QNAN16 : (sg | 16'h7C00);
        if (ex >= 143) return sg | 16'h7C00;
        if (ex >= 113) begin
            h = sg | 16'((ex - 112) << 10) | 16'(mant >> 13);
            rem = mant & 32'h1FFF;
            if (rem > 32'h1000 || (rem == 32'h1000 && h[0])) h++;
            return h;
        end
        if (ex < 102) return sg;
        mant = mant | 32'h80_0000;
        sh = 126 - ex;
        q = mant >> sh;
        rem = mant & ((32'd1 << sh) - 1);
        half = 32'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0])) q++;
        return sg | q[15:0];
    endfunction

    function automatic logic [31:0] widen16(logic [15:0] h);
        int ex;
        logic [9:0] mant;
        ex = int'(h[14:10]);
        mant = h[9:0];
        if (ex == 31) return {h[15], 8'hFF, mant, 13'd0};
        if (ex != 0) return {h[15], 8'(ex + 112), mant, 13'd0};
        if (mant == 0) return {h[15], 31'd0};
        ex = 113;
        while (!mant[9]) begin
            mant = mant << 1;
            ex--;
        end
        return {h[15], 8'(ex - 1), mant[8:0], 14'd0};
    endfunction

    function automatic int clamp_dim(logic [3:0] d);
        if (d == 0) return 1;
        if (d > 8) return 8;
        return int'(d);
    endfunction

    // runs one accepted request against the predictor state
    function automatic void apply_req(t_req r);
        int dm, dn, dk, ai, bi, ci;
        logic [31:0] acc, res;
        logic [15:0] h;
        t_elem ex;
        case (r.act)
            ACT_LOAD_A: mat_a[r.slot] = r.elem;
            ACT_LOAD_B: mat_b[r.slot] = r.elem;
            ACT_LOAD_C: mat_c[r.slot] = r.elem;
            default: begin
                dm = clamp_dim(p_m);
                dn = clamp_dim(p_n);
                dk = clamp_dim(p_k);
                for (int m = 0; m < dm; m++) begin
                    for (int n = 0; n < dn; n++) begin
                        ci = m * dn + n;
                        acc = 32'd0;
                        for (int k = 0; k < dk; k++) begin
                            ai = p_trans_a ? (k * dm + m) : (m * dk + k);
                            bi = p_trans_b ? (n * dk + k) : (k * dn + n);
                            acc = fadd32(acc, fmul32(mat_a[ai], mat_b[bi]));
                        end
                        res = fmul32(p_alpha, acc);
                        if (p_beta[30:0] != 0) res = fadd32(res, fmul32(p_beta, mat_c[ci]));
                        if (is_nan32(res)) res = QNAN32;
                        if (p_half) begin
                            h = narrow16(res);
                            mat_c[ci] = widen16(h);
                            res = {16'd0, h};
                        end else begin
                            mat_c[ci] = res;
                        end
                        ex.row = 3'(m);
                        ex.col = 3'(n);
                        ex.bits = res;
                        ex.last = (m == dm - 1) && (n == dn - 1);
                        c_expect_q.push_back(ex);
                    end
                end
            end
        endcase
    endfunction

    // request source
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_req(cur_req);
                n_acc++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (idle_en && req_q.size() > 0 && $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(0, 7);
                    s_axis_tvalid <= 1'b0;
                end else if (req_q.size() > 0) begin
                    cur_req = req_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {cur_req.elem, cur_req.slot, cur_req.act};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result sink and checker
    always @(posedge i_clk) begin
        t_elem ex;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (c_expect_q.size() == 0) begin
                    $display("%0t: unexpected result tdata=%h last=%b", $time,
                             m_axis_tdata, m_axis_tlast);
                    n_errors++;
                end else begin
                    ex = c_expect_q.pop_front();
                    if (m_axis_tdata[2:0] !== ex.row) begin
                        $display("%0t: out_row exp %0d got %0d", $time, ex.row,
                                 m_axis_tdata[2:0]);
                        n_errors++;
                    end
                    if (m_axis_tdata[5:3] !== ex.col) begin
                        $display("%0t: out_col exp %0d got %0d", $time, ex.col,
                                 m_axis_tdata[5:3]);
                        n_errors++;
                    end
                    if (m_axis_tdata[37:6] !== ex.bits) begin
                        $display("%0t: out_bits exp %h got %h", $time, ex.bits,
                                 m_axis_tdata[37:6]);
                        n_errors++;
                    end
                    if (m_axis_tlast !== ex.last) begin
                        $display("%0t: last exp %b got %b", $time, ex.last, m_axis_tlast);
                        n_errors++;
                    end
                end
            end
            if (snk_stall > 0) begin
                snk_stall--;
                m_axis_tready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                snk_stall = $urandom_range(0, 7);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic push_req(t_action act, logic [5:0] slot, logic [31:0] elem);
        t_req r;
        r.act = act;
        r.slot = slot;
        r.elem = elem;
        req_q.push_back(r);
        n_sent++;
        if (act == ACT_LOAD_A) seen_a[slot] = 1'b1;
        if (act == ACT_LOAD_B) seen_b[slot] = 1'b1;
        if (act == ACT_LOAD_C) seen_c[slot] = 1'b1;
    endtask

    task automatic wait_idle();
        while (n_acc != n_sent || c_expect_q.size() > 0 || !s_axis_tready)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_TRANS_A: p_trans_a = val[0];
            CFG_TRANS_B: p_trans_b = val[0];
            CFG_ROWS_M:  p_m = val[3:0];
            CFG_COLS_N:  p_n = val[3:0];
            CFG_DEPTH_K: p_k = val[3:0];
            CFG_ALPHA:   p_alpha = val;
            CFG_BETA:    p_beta = val;
            default:     p_half = val[0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic cfg_all(bit ta, bit tb_, logic [3:0] m, logic [3:0] n, logic [3:0] k,
                           logic [31:0] alpha, logic [31:0] beta, bit half);
        cfg_write(CFG_TRANS_A, {31'd0, ta});
        cfg_write(CFG_TRANS_B, {31'd0, tb_});
        cfg_write(CFG_ROWS_M, {28'd0, m});
        cfg_write(CFG_COLS_N, {28'd0, n});
        cfg_write(CFG_DEPTH_K, {28'd0, k});
        cfg_write(CFG_ALPHA, alpha);
        cfg_write(CFG_BETA, beta);
        cfg_write(CFG_HALF, {31'd0, half});
    endtask

    function automatic logic [31:0] rand_fp();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 15))
            0: return r;
            1: return {r[31], 31'd0};
            2: return {r[31], 8'hFF, 23'd0};
            3: return {1'b0, 8'hFF, r[22:1], 1'b1};
            4: return {r[31], 8'd0, r[22:0]};
            5: return {r[31], 31'h7F7F_FFFF};
            default: return {r[31], 8'($urandom_range(118, 136)), r[22:0]};
        endcase
    endfunction

    function automatic logic [3:0] rand_dim();
        case ($urandom_range(0, 15))
            0: return 4'd0;
            1: return 4'd15;
            2: return 4'd8;
            default: return 4'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic logic [31:0] rand_scale();
        case ($urandom_range(0, 5))
            0: return 32'h3F80_0000;
            1: return {$urandom_range(0, 1) == 1, 31'd0};
            default: return rand_fp();
        endcase
    endfunction

    initial begin
        logic [31:0] dir_a[6], dir_b[6], dir_c[6];
        int dm, dn, dk;
        bit need_c;
        p_trans_a = 0; p_trans_b = 0; p_half = 0;
        p_m = 1; p_n = 1; p_k = 1;
        p_alpha = 32'h3F80_0000; p_beta = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: NaN from inf*0, overflow, subnormal rounding, then fp16 pass
        dir_a = '{32'h7F80_0000, 32'h7F7F_FFFF, 32'h8000_0001,
                  32'h477F_E000, 32'h3F80_0000, 32'h7FC0_0001};
        dir_b = '{32'h0000_0000, 32'h4000_0000, 32'h3F40_0000,
                  32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000};
        dir_c = '{32'h3F80_0000, 32'h0000_0000, 32'h4000_0000,
                  32'h0000_0000, 32'hBF80_0000, 32'h0000_0001};
        cfg_all(0, 0, 1, 1, 1, 32'h3F80_0000, 32'h8000_0000, 0);
        for (int i = 0; i < 6; i++) begin
            if (i == 3) begin
                wait_idle();
                cfg_all(1, 1, 1, 1, 1, 32'h4000_0000, 32'h3F80_0000, 1);
            end
            push_req(ACT_LOAD_A, 6'd0, dir_a[i]);
            push_req(ACT_LOAD_B, 6'd0, dir_b[i]);
            push_req(ACT_LOAD_C, 6'd0, dir_c[i]);
            push_req(ACT_START, 6'd0, $urandom);
        end

        while (n_sent < 280) begin
            wait_idle();
            if (n_sent > 220) idle_en = 1'b0;
            cfg_all($urandom_range(0, 1), $urandom_range(0, 1), rand_dim(), rand_dim(),
                    rand_dim(), rand_scale(), rand_scale(), $urandom_range(0, 1));
            dm = clamp_dim(p_m);
            dn = clamp_dim(p_n);
            dk = clamp_dim(p_k);
            need_c = p_beta[30:0] != 0;
            repeat ($urandom_range(1, 2)) begin
                for (int s = 0; s < dm * dk; s++)
                    if (!seen_a[s] || $urandom_range(0, 2) == 0)
                        push_req(ACT_LOAD_A, 6'(s), rand_fp());
                for (int s = 0; s < dk * dn; s++)
                    if (!seen_b[s] || $urandom_range(0, 2) == 0)
                        push_req(ACT_LOAD_B, 6'(s), rand_fp());
                if (need_c)
                    for (int s = 0; s < dm * dn; s++)
                        if (!seen_c[s] || $urandom_range(0, 3) == 0)
                            push_req(ACT_LOAD_C, 6'(s), rand_fp());
                repeat ($urandom_range(0, 3))
                    push_req(t_action'($urandom_range(0, 2)), 6'($urandom), rand_fp());
                push_req(ACT_START, 6'($urandom), $urandom);
            end
        end

        wait_idle();
        repeat (200) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sgemm_pkg.sv
rtl/sgemm_fpu.sv
rtl/small_gemm_alpha_beta.sv
tb/tb.sv
